[design/psm_pkg.sv]
// Shared constants and types for the planar shadow matrix unit
package psm_pkg;

  localparam int CFG_IDX_W = 2;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_LIGHT_X,
    REG_LIGHT_Y,
    REG_LIGHT_Z,
    REG_LIGHT_W
  } cfg_reg_t;

  typedef logic signed [31:0] q16_t;

  localparam q16_t LIGHT_X_RST = 32'sd3276800;
  localparam q16_t LIGHT_Y_RST = 32'sd6553600;
  localparam q16_t LIGHT_Z_RST = -32'sd3276800;
  localparam q16_t LIGHT_W_RST = 32'sd0;
  localparam q16_t Q16_MAX     = 32'sh7fffffff;
  localparam q16_t Q16_MIN     = 32'sh80000000;

  localparam int FRONT_STAGES = 11;
  localparam int SQRT_BITS    = 31;
  localparam int DIV_BITS     = 17;
  localparam int BACK_STAGES  = 7;
  localparam int NSTG         = FRONT_STAGES + SQRT_BITS + 1 + DIV_BITS + BACK_STAGES;

  typedef struct packed {
    logic [2:0][31:0] p2;
    logic             degen;
    logic [2:0]       neg;
    logic [2:0][30:0] mag;
  } sqc_t;

  typedef struct packed {
    logic [2:0][31:0] p2;
    logic             degen;
    logic [2:0]       neg;
    logic [30:0]      len;
  } dvc_t;

endpackage

[design/planar_shadow_matrix_unit.sv]
// Planar shadow projection matrix unit: pipelined plane fit and matrix build
//
//  channel | direction | handshake         | payload
//  cfg     | in        | cfg_we            | cfg_index, cfg_data
//  in      | in        | in_valid/in_stall | p0_x .. p2_z
//  out     | out       | out_valid/out_stall | column, row_zero..row_three, degenerate, last
//
//  An item crosses 67 register stages and then the column buffer; the square root takes one
//  stage per result bit (31) and the normalising divide one stage per quotient bit (17).
//  Four column transfers leave per item, one per cycle while out_stall is low; the column
//  buffer holds one item and takes the next only when empty or on its last column.
//  Reset clears the valid bits, the column buffer's valid flag and its column count, and
//  loads the light defaults. Every stage freezes while the last stage holds an item
//  that the column buffer cannot yet take.
module planar_shadow_matrix_unit import psm_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]          cfg_data,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic signed [31:0]   p0_x,
  input  logic signed [31:0]   p0_y,
  input  logic signed [31:0]   p0_z,
  input  logic signed [31:0]   p1_x,
  input  logic signed [31:0]   p1_y,
  input  logic signed [31:0]   p1_z,
  input  logic signed [31:0]   p2_x,
  input  logic signed [31:0]   p2_y,
  input  logic signed [31:0]   p2_z,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [1:0]           column,
  output logic signed [31:0]   row_zero,
  output logic signed [31:0]   row_one,
  output logic signed [31:0]   row_two,
  output logic signed [31:0]   row_three,
  output logic                 degenerate,
  output logic                 last
);

  localparam int LAST = NSTG - 1;

  function automatic logic [32:0] mag33(input logic signed [32:0] x);
    return x[32] ? $unsigned(-x) : $unsigned(x);
  endfunction

  function automatic logic [61:0] mag62(input logic signed [63:0] x);
    logic [63:0] m;
    m = x[63] ? $unsigned(-x) : $unsigned(x);
    return m[61:0];
  endfunction

  function automatic logic [2:0] msb8(input logic [7:0] g);
    logic [2:0] r;
    r = '0;
    for (int i = 0; i < 8; i++) begin
      if (g[i]) r = 3'(i);
    end
    return r;
  endfunction

  function automatic q16_t rsat(input logic signed [65:0] v);
    logic signed [65:0] t;
    t = (v + 66'sd32768) >>> 16;
    if (t > 66'sd2147483647) return Q16_MAX;
    else if (t < -66'sd2147483648) return Q16_MIN;
    else return t[31:0];
  endfunction

  q16_t light_x, light_y, light_z, light_w;
  q16_t lt [4];
  logic [NSTG-1:0] vld;
  logic adv;

  logic ser_v, ser_deg;
  logic [1:0] col;
  q16_t ser_m [4][4];

  always_ff @(posedge clk) begin
    if (rst) begin
      light_x <= LIGHT_X_RST;
      light_y <= LIGHT_Y_RST;
      light_z <= LIGHT_Z_RST;
      light_w <= LIGHT_W_RST;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_LIGHT_X: light_x <= cfg_data;
        REG_LIGHT_Y: light_y <= cfg_data;
        REG_LIGHT_Z: light_z <= cfg_data;
        REG_LIGHT_W: light_w <= cfg_data;
        default: ;
      endcase
    end
  end

  assign lt[0] = light_x;
  assign lt[1] = light_y;
  assign lt[2] = light_z;
  assign lt[3] = light_w;

  assign adv      = !vld[LAST] || !ser_v || (col == 2'd3 && !out_stall);
  assign in_stall = !adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[NSTG-2:0], in_valid};
    end
  end

  // edges
  logic signed [32:0] s1_ea [3], s1_eb [3];
  logic [2:0][31:0] s1_p2;
  always_ff @(posedge clk) begin
    if (adv) begin
      s1_ea[0] <= 33'(p1_x) - 33'(p0_x);
      s1_ea[1] <= 33'(p1_y) - 33'(p0_y);
      s1_ea[2] <= 33'(p1_z) - 33'(p0_z);
      s1_eb[0] <= 33'(p2_x) - 33'(p0_x);
      s1_eb[1] <= 33'(p2_y) - 33'(p0_y);
      s1_eb[2] <= 33'(p2_z) - 33'(p0_z);
      s1_p2    <= {p2_z, p2_y, p2_x};
    end
  end

  // edge scaling
  logic [32:0] e_or;
  logic [1:0] esh;
  always_comb begin
    e_or = '0;
    for (int k = 0; k < 3; k++) begin
      e_or = e_or | mag33(s1_ea[k]) | mag33(s1_eb[k]);
    end
    if (e_or[32]) esh = 2'd3;
    else if (e_or[31]) esh = 2'd2;
    else if (e_or[30]) esh = 2'd1;
    else esh = 2'd0;
  end

  logic signed [31:0] s2_ea [3], s2_eb [3];
  logic [2:0][31:0] s2_p2;
  always_ff @(posedge clk) begin
    if (adv) begin
      for (int k = 0; k < 3; k++) begin
        s2_ea[k] <= 32'(s1_ea[k] >>> esh);
        s2_eb[k] <= 32'(s1_eb[k] >>> esh);
      end
      s2_p2 <= s1_p2;
    end
  end

  // cross product
  logic signed [63:0] s3_pr [6];
  logic [2:0][31:0] s3_p2;
  always_ff @(posedge clk) begin
    if (adv) begin
      s3_pr[0] <= 64'(s2_ea[1]) * 64'(s2_eb[2]);
      s3_pr[1] <= 64'(s2_eb[1]) * 64'(s2_ea[2]);
      s3_pr[2] <= 64'(s2_eb[0]) * 64'(s2_ea[2]);
      s3_pr[3] <= 64'(s2_ea[0]) * 64'(s2_eb[2]);
      s3_pr[4] <= 64'(s2_ea[0]) * 64'(s2_eb[1]);
      s3_pr[5] <= 64'(s2_eb[0]) * 64'(s2_ea[1]);
      s3_p2    <= s2_p2;
    end
  end

  logic signed [63:0] s4_c [3];
  logic s4_deg;
  logic [2:0][31:0] s4_p2;
  always_ff @(posedge clk) begin
    if (adv) begin
      s4_c[0] <= s3_pr[0] - s3_pr[1];
      s4_c[1] <= s3_pr[2] - s3_pr[3];
      s4_c[2] <= s3_pr[4] - s3_pr[5];
      s4_deg  <= (s3_pr[0] == s3_pr[1]) && (s3_pr[2] == s3_pr[3]) && (s3_pr[4] == s3_pr[5]);
      s4_p2   <= s3_p2;
    end
  end

  // block exponent search
  logic signed [63:0] s5_c [3];
  logic [61:0] s5_or;
  logic s5_deg;
  logic [2:0][31:0] s5_p2;
  always_ff @(posedge clk) begin
    if (adv) begin
      s5_c   <= s4_c;
      s5_or  <= mag62(s4_c[0]) | mag62(s4_c[1]) | mag62(s4_c[2]);
      s5_deg <= s4_deg;
      s5_p2  <= s4_p2;
    end
  end

  logic [63:0] or_pad;
  assign or_pad = {2'b00, s5_or};

  logic signed [63:0] s6_c [3];
  logic [7:0] s6_nz;
  logic [7:0][2:0] s6_pos;
  logic s6_deg;
  logic [2:0][31:0] s6_p2;
  always_ff @(posedge clk) begin
    if (adv) begin
      for (int g = 0; g < 8; g++) begin
        s6_nz[g]  <= |or_pad[8*g +: 8];
        s6_pos[g] <= msb8(or_pad[8*g +: 8]);
      end
      s6_c   <= s5_c;
      s6_deg <= s5_deg;
      s6_p2  <= s5_p2;
    end
  end

  logic [5:0] msb;
  always_comb begin
    msb = '0;
    for (int g = 0; g < 8; g++) begin
      if (s6_nz[g]) msb = {3'(g), s6_pos[g]};
    end
  end

  logic signed [63:0] s7_c [3];
  logic s7_right;
  logic [5:0] s7_amt;
  logic s7_deg;
  logic [2:0][31:0] s7_p2;
  always_ff @(posedge clk) begin
    if (adv) begin
      s7_right <= msb > 6'd29;
      s7_amt   <= (msb > 6'd29) ? msb - 6'd29 : 6'd29 - msb;
      s7_c     <= s6_c;
      s7_deg   <= s6_deg;
      s7_p2    <= s6_p2;
    end
  end

  logic signed [31:0] s8_cn [3];
  logic s8_deg;
  logic [2:0][31:0] s8_p2;
  always_ff @(posedge clk) begin
    if (adv) begin
      for (int k = 0; k < 3; k++) begin
        s8_cn[k] <= s7_right ? 32'(s7_c[k] >>> s7_amt) : 32'(s7_c[k] <<< s7_amt);
      end
      s8_deg <= s7_deg;
      s8_p2  <= s7_p2;
    end
  end

  sqc_t s9_cr;
  always_ff @(posedge clk) begin
    if (adv) begin
      for (int k = 0; k < 3; k++) begin
        s9_cr.neg[k] <= s8_cn[k][31];
        s9_cr.mag[k] <= s8_cn[k][31] ? 31'(-s8_cn[k]) : 31'(s8_cn[k]);
      end
      s9_cr.degen <= s8_deg;
      s9_cr.p2    <= s8_p2;
    end
  end

  logic [61:0] s10_sq [3];
  sqc_t s10_cr;
  always_ff @(posedge clk) begin
    if (adv) begin
      for (int k = 0; k < 3; k++) begin
        s10_sq[k] <= 62'(s9_cr.mag[k]) * 62'(s9_cr.mag[k]);
      end
      s10_cr <= s9_cr;
    end
  end

  // square root, one result bit per stage
  logic [63:0] sq_rem  [0:SQRT_BITS];
  logic [30:0] sq_root [0:SQRT_BITS];
  sqc_t        sq_cr   [0:SQRT_BITS];

  always_ff @(posedge clk) begin
    if (adv) begin
      sq_rem[0]  <= 64'(s10_sq[0]) + 64'(s10_sq[1]) + 64'(s10_sq[2]);
      sq_root[0] <= '0;
      sq_cr[0]   <= s10_cr;
    end
  end

  for (genvar j = 0; j < SQRT_BITS; j++) begin : g_sqrt
    localparam int B = SQRT_BITS - 1 - j;
    logic [63:0] trial;
    logic take;
    assign trial = (64'(sq_root[j]) << (B + 1)) | (64'd1 << (2 * B));
    assign take  = sq_rem[j] >= trial;
    always_ff @(posedge clk) begin
      if (adv) begin
        sq_rem[j+1]  <= take ? sq_rem[j] - trial : sq_rem[j];
        sq_root[j+1] <= take ? sq_root[j] | (31'd1 << B) : sq_root[j];
        sq_cr[j+1]   <= sq_cr[j];
      end
    end
  end

  // normalising divide, one quotient bit per stage in three lanes
  logic [2:0][47:0] dv_rem [0:DIV_BITS];
  logic [2:0][16:0] dv_q   [0:DIV_BITS];
  dvc_t             dv_cr  [0:DIV_BITS];

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int k = 0; k < 3; k++) begin
        dv_rem[0][k] <= (48'(sq_cr[SQRT_BITS].mag[k]) << 16) + 48'(sq_root[SQRT_BITS] >> 1);
      end
      dv_q[0]        <= '0;
      dv_cr[0].p2    <= sq_cr[SQRT_BITS].p2;
      dv_cr[0].degen <= sq_cr[SQRT_BITS].degen;
      dv_cr[0].neg   <= sq_cr[SQRT_BITS].neg;
      dv_cr[0].len   <= sq_root[SQRT_BITS];
    end
  end

  for (genvar j = 0; j < DIV_BITS; j++) begin : g_div
    localparam int B = DIV_BITS - 1 - j;
    logic [47:0] dsr;
    assign dsr = 48'(dv_cr[j].len) << B;
    always_ff @(posedge clk) begin
      if (adv) begin
        for (int k = 0; k < 3; k++) begin
          if (dv_rem[j][k] >= dsr) begin
            dv_rem[j+1][k] <= dv_rem[j][k] - dsr;
            dv_q[j+1][k]   <= dv_q[j][k] | (17'd1 << B);
          end else begin
            dv_rem[j+1][k] <= dv_rem[j][k];
            dv_q[j+1][k]   <= dv_q[j][k];
          end
        end
        dv_cr[j+1] <= dv_cr[j];
      end
    end
  end

  // plane
  logic signed [17:0] n_n [3];
  logic n_deg;
  logic [2:0][31:0] n_p2;
  always_ff @(posedge clk) begin
    if (adv) begin
      for (int k = 0; k < 3; k++) begin
        if (dv_cr[DIV_BITS].degen) n_n[k] <= '0;
        else if (dv_cr[DIV_BITS].neg[k]) n_n[k] <= -$signed(18'(dv_q[DIV_BITS][k]));
        else n_n[k] <= $signed(18'(dv_q[DIV_BITS][k]));
      end
      n_deg <= dv_cr[DIV_BITS].degen;
      n_p2  <= dv_cr[DIV_BITS].p2;
    end
  end

  logic signed [49:0] np_pr [3];
  logic signed [17:0] np_n [3];
  logic np_deg;
  always_ff @(posedge clk) begin
    if (adv) begin
      for (int k = 0; k < 3; k++) begin
        np_pr[k] <= 50'(n_n[k]) * 50'($signed(n_p2[k]));
      end
      np_n   <= n_n;
      np_deg <= n_deg;
    end
  end

  logic signed [51:0] na_acc;
  logic signed [17:0] na_n [3];
  logic na_deg;
  always_ff @(posedge clk) begin
    if (adv) begin
      na_acc <= -(52'(np_pr[0]) + 52'(np_pr[1]) + 52'(np_pr[2]));
      na_n   <= np_n;
      na_deg <= np_deg;
    end
  end

  q16_t pl [4];
  logic pl_deg;
  always_ff @(posedge clk) begin
    if (adv) begin
      for (int k = 0; k < 3; k++) begin
        pl[k] <= 32'(na_n[k]);
      end
      pl[3]  <= rsat(66'(na_acc));
      pl_deg <= na_deg;
    end
  end

  // matrix
  logic signed [63:0] mp [4][4];
  logic mp_deg;
  always_ff @(posedge clk) begin
    if (adv) begin
      for (int r = 0; r < 4; r++) begin
        for (int c = 0; c < 4; c++) begin
          mp[r][c] <= 64'(lt[r]) * 64'(pl[c]);
        end
      end
      mp_deg <= pl_deg;
    end
  end

  logic signed [65:0] me_next [4][4];
  always_comb begin
    for (int r = 0; r < 4; r++) begin
      for (int c = 0; c < 4; c++) begin
        if (r == c) begin
          me_next[r][c] = '0;
          for (int i = 0; i < 4; i++) begin
            if (i != c) me_next[r][c] = me_next[r][c] + 66'(mp[i][i]);
          end
        end else begin
          me_next[r][c] = -66'(mp[r][c]);
        end
      end
    end
  end

  logic signed [65:0] me [4][4];
  logic me_deg;
  always_ff @(posedge clk) begin
    if (adv) begin
      me     <= me_next;
      me_deg <= mp_deg;
    end
  end

  q16_t mr [4][4];
  logic mr_deg;
  always_ff @(posedge clk) begin
    if (adv) begin
      for (int r = 0; r < 4; r++) begin
        for (int c = 0; c < 4; c++) begin
          mr[r][c] <= rsat(me[r][c]);
        end
      end
      mr_deg <= me_deg;
    end
  end

  // column buffer
  always_ff @(posedge clk) begin
    if (rst) begin
      ser_v <= 1'b0;
      col   <= '0;
    end else if (vld[LAST] && adv) begin
      ser_v <= 1'b1;
      col   <= '0;
    end else if (ser_v && !out_stall) begin
      col <= col + 2'd1;
      if (col == 2'd3) ser_v <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (vld[LAST] && adv) begin
      ser_m   <= mr;
      ser_deg <= mr_deg;
    end
  end

  assign out_valid  = ser_v;
  assign column     = col;
  assign row_zero   = ser_m[0][col];
  assign row_one    = ser_m[1][col];
  assign row_two    = ser_m[2][col];
  assign row_three  = ser_m[3][col];
  assign degenerate = ser_deg;
  assign last       = (col == 2'd3);

  a_col_step: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_stall && !last |=> out_valid && column == $past(column) + 2'd1)
    else $error("column sequence broken");

  a_deg_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && degenerate |->
      row_zero == 0 && row_one == 0 && row_two == 0 && row_three == 0)
    else $error("degenerate result carries nonzero entries");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    in_stall |=> vld == $past(vld))
    else $error("pipeline moved while stalled");

  a_no_overrun: assert property (@(posedge clk) disable iff (rst)
    vld[LAST] && out_valid && !last |-> in_stall)
    else $error("column buffer overrun");

endmodule
